// ===== hw/rtl/bar_pkg.sv =====
// shared types, constants and helper functions for the button auto-repeat block
// no dependencies; every other file of the block refers to this package
package bar_pkg;

   localparam int TIME_W        = 40;
   localparam int BTN_W         = 32;
   localparam int CFG_W         = 16;
   localparam int CMD_W         = 2;
   localparam int CSR_IDX_W     = 2;
   localparam int LANES_DEFAULT = 6;
   localparam int LANE_IDX_W    = 5;

   localparam logic [TIME_W-1:0] TIME_MAX       = '1;
   localparam logic [CFG_W-1:0]  DELAY_RESET    = 16'd350;
   localparam logic [CFG_W-1:0]  INTERVAL_RESET = 16'd80;

   // remainder unit retires this many dividend bits per cycle
   localparam int REM_DIGIT_W = 4;
   localparam int REM_STEPS   = TIME_W / REM_DIGIT_W;
   localparam int REM_CNT_W   = $clog2(REM_STEPS);

   // button bit positions
   localparam int BTN_L     = 6;
   localparam int BTN_R     = 7;
   localparam int BTN_LEFT  = 12;
   localparam int BTN_UP    = 13;
   localparam int BTN_RIGHT = 14;
   localparam int BTN_DOWN  = 15;
   localparam int LS_LEFT   = 16;
   localparam int LS_UP     = 17;
   localparam int LS_RIGHT  = 18;
   localparam int LS_DOWN   = 19;
   localparam int RS_LEFT   = 20;
   localparam int RS_UP     = 21;
   localparam int RS_RIGHT  = 22;
   localparam int RS_DOWN   = 23;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK  = 2'd0,
      CMD_POLL  = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_NOP   = 2'd3
   } command_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INITIAL_DELAY   = 2'd0,
      CSR_REPEAT_INTERVAL = 2'd1
   } csr_index_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic apply;
      logic lane_next;
      logic rem_start;
      logic fire_write;
      logic rsp_load;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      command_type command;
      logic        lane_fires;
      logic        lane_last;
      logic        rem_done;
   } dp_stat_type;

   // or stick directions onto the d-pad bits
   function automatic logic [BTN_W-1:0] merge_sticks(input logic [BTN_W-1:0] w);
      logic [BTN_W-1:0] m;
      m            = w;
      m[BTN_UP]    = w[BTN_UP]    | w[LS_UP]    | w[RS_UP];
      m[BTN_DOWN]  = w[BTN_DOWN]  | w[LS_DOWN]  | w[RS_DOWN];
      m[BTN_LEFT]  = w[BTN_LEFT]  | w[LS_LEFT]  | w[RS_LEFT];
      m[BTN_RIGHT] = w[BTN_RIGHT] | w[LS_RIGHT] | w[RS_RIGHT];
      return m;
   endfunction

   // button bit owned by a lane; lanes past the sixth own none
   function automatic logic [BTN_W-1:0] lane_bit(input logic [LANE_IDX_W-1:0] lane);
      logic [BTN_W-1:0] b;
      case (lane)
         5'd0:    b = BTN_W'(1) << BTN_UP;
         5'd1:    b = BTN_W'(1) << BTN_DOWN;
         5'd2:    b = BTN_W'(1) << BTN_LEFT;
         5'd3:    b = BTN_W'(1) << BTN_RIGHT;
         5'd4:    b = BTN_W'(1) << BTN_L;
         5'd5:    b = BTN_W'(1) << BTN_R;
         default: b = '0;
      endcase
      return b;
   endfunction

endpackage

// ===== hw/rtl/bar_req_if.sv =====
// request channel of the button auto-repeat block
// depends on bar_pkg for field widths
interface bar_req_if;
   logic                        valid;
   logic                        ready;
   logic [bar_pkg::CMD_W-1:0]   command;
   logic [bar_pkg::BTN_W-1:0]   buttons_pressed;
   logic [bar_pkg::BTN_W-1:0]   buttons_held;
   logic [bar_pkg::BTN_W-1:0]   repeat_mask;

   modport source (output valid, command, buttons_pressed, buttons_held, repeat_mask,
                   input ready);
   modport sink (input valid, command, buttons_pressed, buttons_held, repeat_mask,
                 output ready);
endinterface

// ===== hw/rtl/bar_rsp_if.sv =====
// response channel of the button auto-repeat block
// depends on bar_pkg for field widths
interface bar_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [bar_pkg::BTN_W-1:0] pressed_remapped;
   logic [bar_pkg::BTN_W-1:0] repeated;

   modport source (output valid, pressed_remapped, repeated, input ready);
   modport sink (input valid, pressed_remapped, repeated, output ready);
endinterface

// ===== hw/rtl/bar_csr_if.sv =====
// register write channel of the button auto-repeat block
// depends on bar_pkg for index and data widths
interface bar_csr_if;
   logic                          valid;
   logic                          ready;
   logic [bar_pkg::CSR_IDX_W-1:0] index;
   logic [bar_pkg::CFG_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/button_auto_repeat.sv =====
// top level of the button auto-repeat block: joins controller and datapath to the channels
// depends on bar_pkg, bar_req_if, bar_rsp_if, bar_csr_if, bar_ctrl and bar_dp
//
// Typematic auto-repeat for up, down, left, right, L and R. Each request word carries a
// command: a tick moves the millisecond counter on by one (it stops at 2^40-1), a poll
// merges stick directions onto the d-pad bits and arms or disarms the lanes, and a query
// reports the masked lanes whose repeat is due, then moves each of those fire times past
// now by whole intervals. Every request gives exactly one response word. A tick, a poll or
// an unused command holds the block from the accept through the execute and done states;
// its response word is registered on leaving done, once the output register is free. A
// query visits the lanes one per cycle while none fires; each lane that fires waits while
// the catch-up remainder unit retires four bits of the 40-bit time gap per cycle.
// One request is in work at a time; a new request is taken while the previous response
// still waits in the output register. The user must write the two timing registers only
// while no request is in work (the block does not check); the register port never stalls.
module button_auto_repeat #(
   parameter int LANES = bar_pkg::LANES_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   bar_req_if.sink   req_ch,
   bar_rsp_if.source rsp_ch,
   bar_csr_if.sink   csr_ch
);

   bar_pkg::ctrl_cmd_type cmd;
   bar_pkg::dp_stat_type  stat;
   logic                  csr_write;

   // timing registers are plain flops, so writes always land
   assign csr_ch.ready = 1'b1;
   assign csr_write    = csr_ch.valid && csr_ch.ready;

   // sequencer: request handshake, lane scan, response valid
   bar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // state, lane registers, catch-up unit and response word
   bar_dp #(
      .LANES (LANES)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .req_command          (req_ch.command),
      .req_buttons_pressed  (req_ch.buttons_pressed),
      .req_buttons_held     (req_ch.buttons_held),
      .req_repeat_mask      (req_ch.repeat_mask),
      .csr_write            (csr_write),
      .csr_index            (csr_ch.index),
      .csr_data             (csr_ch.data),
      .cmd                  (cmd),
      .stat                 (stat),
      .rsp_pressed_remapped (rsp_ch.pressed_remapped),
      .rsp_repeated         (rsp_ch.repeated)
   );

endmodule

// ===== hw/rtl/bar_rem.sv =====
// iterative remainder unit: 40-bit dividend modulo 16-bit divisor, four bits a cycle
// depends on bar_pkg
module bar_rem (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [bar_pkg::TIME_W-1:0]  dividend,
   input  logic [bar_pkg::CFG_W-1:0]   divisor,
   output logic                        busy,
   output logic                        done,
   output logic [bar_pkg::CFG_W-1:0]   remainder
);

   logic [bar_pkg::TIME_W-1:0]    num_ff, num_in;
   logic [bar_pkg::CFG_W-1:0]     rem_ff, rem_in;
   logic [bar_pkg::CFG_W-1:0]     div_ff;
   logic [bar_pkg::REM_CNT_W-1:0] cnt_ff;
   logic                          busy_ff;
   logic                          done_ff;

   // restoring steps, remainder stays below the divisor
   always_comb begin
      logic [bar_pkg::CFG_W:0] trial;
      num_in = num_ff;
      rem_in = rem_ff;
      for (int k = 0; k < bar_pkg::REM_DIGIT_W; k++) begin
         trial  = {rem_in, num_in[bar_pkg::TIME_W-1]};
         num_in = num_in << 1;
         if (trial >= {1'b0, div_ff}) begin
            trial = trial - {1'b0, div_ff};
         end
         rem_in = trial[bar_pkg::CFG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + bar_pkg::REM_CNT_W'(1);
            if (cnt_ff == bar_pkg::REM_CNT_W'(bar_pkg::REM_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign remainder = rem_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("remainder unit restarted while busy");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff)
      else $error("remainder done without a finished run");

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff < div_ff)
      else $error("remainder not below divisor");

endmodule

// ===== hw/rtl/bar_ctrl.sv =====
// controller of the button auto-repeat block: sequences commands and the lane scan
// depends on bar_pkg for command and status structs
module bar_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output bar_pkg::ctrl_cmd_type cmd,
   input  bar_pkg::dp_stat_type  stat
);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_EXEC  = 6'b000010,
      S_CHECK = 6'b000100,
      S_DIV   = 6'b001000,
      S_WB    = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.apply = 1'b1;
            state_in  = (stat.command == bar_pkg::CMD_QUERY) ? S_CHECK : S_DONE;
         end
         S_CHECK: begin
            if (stat.lane_fires) begin
               cmd.rem_start = 1'b1;
               state_in      = S_DIV;
            end else if (stat.lane_last) begin
               state_in = S_DONE;
            end else begin
               cmd.lane_next = 1'b1;
            end
         end
         S_DIV: begin
            if (stat.rem_done) begin
               state_in = S_WB;
            end
         end
         S_WB: begin
            cmd.fire_write = 1'b1;
            if (stat.lane_last) begin
               state_in = S_DONE;
            end else begin
               cmd.lane_next = 1'b1;
               state_in      = S_CHECK;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_EXEC)
      else $error("accepted word not executed");

   a_done_delivers: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && slot_free |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("finished word not placed in output register");

   a_div_waits: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV && !stat.rem_done |=> state_ff == S_DIV)
      else $error("left catch-up before remainder done");

endmodule

// ===== hw/rtl/bar_dp.sv =====
// datapath of the button auto-repeat block: time, button words, lanes, config, output word
// depends on bar_pkg and instantiates bar_rem
module bar_dp #(
   parameter int LANES = bar_pkg::LANES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [bar_pkg::CMD_W-1:0]     req_command,
   input  logic [bar_pkg::BTN_W-1:0]     req_buttons_pressed,
   input  logic [bar_pkg::BTN_W-1:0]     req_buttons_held,
   input  logic [bar_pkg::BTN_W-1:0]     req_repeat_mask,
   input  logic                          csr_write,
   input  logic [bar_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bar_pkg::CFG_W-1:0]     csr_data,
   input  bar_pkg::ctrl_cmd_type         cmd,
   output bar_pkg::dp_stat_type          stat,
   output logic [bar_pkg::BTN_W-1:0]     rsp_pressed_remapped,
   output logic [bar_pkg::BTN_W-1:0]     rsp_repeated
);

   localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int TW     = bar_pkg::TIME_W;
   localparam int BW     = bar_pkg::BTN_W;
   localparam int CW     = bar_pkg::CFG_W;

   // captured request
   bar_pkg::command_type req_cmd_ff;
   logic [BW-1:0]        req_pressed_ff, req_held_ff, req_mask_ff;

   logic [TW-1:0]        time_now_ff, time_now_in;
   logic [BW-1:0]        last_pressed_ff, last_pressed_in;
   logic [BW-1:0]        last_held_ff, last_held_in;
   logic [LANES-1:0]     lane_armed_ff, lane_armed_in;
   logic [TW-1:0]        lane_fire_ff [LANES];
   logic [TW-1:0]        lane_fire_in [LANES];
   logic [CW-1:0]        delay_ff, interval_ff;
   logic [LANE_W-1:0]    lane_ff;
   logic [BW-1:0]        rep_ff;
   logic [BW-1:0]        rsp_pressed_ff, rsp_repeated_ff;

   logic [BW-1:0]        merged_pressed, merged_held;
   logic [BW-1:0]        cur_bit;
   logic [TW-1:0]        cur_fire;
   logic [TW:0]          arm_sum, wb_sum;
   logic [TW-1:0]        arm_time, fire_wb;
   logic [CW-1:0]        interval_eff;
   logic [CW-1:0]        rem_value;
   logic                 rem_busy, rem_done;

   assign merged_pressed = bar_pkg::merge_sticks(req_pressed_ff);
   assign merged_held    = bar_pkg::merge_sticks(req_held_ff);
   assign interval_eff   = (interval_ff == '0) ? CW'(1) : interval_ff;

   // fire time on press, saturating
   assign arm_sum  = {1'b0, time_now_ff} + (TW + 1)'(delay_ff);
   assign arm_time = (arm_sum > {1'b0, bar_pkg::TIME_MAX}) ? bar_pkg::TIME_MAX
                                                          : arm_sum[TW-1:0];

   // catch-up: fire + (diff / iv + 1) * iv equals now - diff % iv + iv
   assign wb_sum  = {1'b0, time_now_ff} - (TW + 1)'(rem_value) + (TW + 1)'(interval_eff);
   assign fire_wb = (wb_sum > {1'b0, bar_pkg::TIME_MAX}) ? bar_pkg::TIME_MAX
                                                        : wb_sum[TW-1:0];

   assign cur_bit  = bar_pkg::lane_bit(bar_pkg::LANE_IDX_W'(lane_ff));
   assign cur_fire = lane_fire_ff[lane_ff];

   assign stat.command    = req_cmd_ff;
   assign stat.lane_fires = (|(req_mask_ff & cur_bit)) && lane_armed_ff[lane_ff]
                            && (|(last_held_ff & cur_bit)) && !(|(last_pressed_ff & cur_bit))
                            && (time_now_ff >= cur_fire);
   assign stat.lane_last  = (lane_ff == LANE_W'(LANES - 1));
   assign stat.rem_done   = rem_done;

   bar_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.rem_start),
      .dividend  (time_now_ff - cur_fire),
      .divisor   (interval_eff),
      .busy      (rem_busy),
      .done      (rem_done),
      .remainder (rem_value)
   );

   // tick and poll act on the whole state at once; a query write-back sets the current lane's fire time
   always_comb begin
      logic [BW-1:0] b;
      b               = '0;
      time_now_in     = time_now_ff;
      last_pressed_in = last_pressed_ff;
      last_held_in    = last_held_ff;
      lane_armed_in   = lane_armed_ff;
      for (int i = 0; i < LANES; i++) begin
         lane_fire_in[i] = lane_fire_ff[i];
      end
      if (cmd.apply && req_cmd_ff == bar_pkg::CMD_TICK) begin
         if (time_now_ff != bar_pkg::TIME_MAX) begin
            time_now_in = time_now_ff + TW'(1);
         end
      end
      if (cmd.apply && req_cmd_ff == bar_pkg::CMD_POLL) begin
         last_pressed_in = merged_pressed;
         last_held_in    = merged_held;
         for (int i = 0; i < LANES; i++) begin
            b = bar_pkg::lane_bit(bar_pkg::LANE_IDX_W'(i));
            if (|(merged_pressed & b)) begin
               lane_armed_in[i] = 1'b1;
               lane_fire_in[i]  = arm_time;
            end else if (!(|(merged_held & b))) begin
               lane_armed_in[i] = 1'b0;
               lane_fire_in[i]  = '0;
            end
         end
      end
      if (cmd.fire_write) begin
         lane_fire_in[lane_ff] = fire_wb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_now_ff     <= '0;
         last_pressed_ff <= '0;
         last_held_ff    <= '0;
         lane_armed_ff   <= '0;
         delay_ff        <= bar_pkg::DELAY_RESET;
         interval_ff     <= bar_pkg::INTERVAL_RESET;
         lane_ff         <= '0;
      end else begin
         time_now_ff     <= time_now_in;
         last_pressed_ff <= last_pressed_in;
         last_held_ff    <= last_held_in;
         lane_armed_ff   <= lane_armed_in;
         if (csr_write) begin
            unique case (csr_index)
               bar_pkg::CSR_INITIAL_DELAY:   delay_ff    <= csr_data;
               bar_pkg::CSR_REPEAT_INTERVAL: interval_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.apply) begin
            lane_ff <= '0;
         end else if (cmd.lane_next) begin
            lane_ff <= lane_ff + LANE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LANES; i++) begin
            lane_fire_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < LANES; i++) begin
            lane_fire_ff[i] <= lane_fire_in[i];
         end
      end
      if (cmd.load_req) begin
         req_cmd_ff     <= bar_pkg::command_type'(req_command);
         req_pressed_ff <= req_buttons_pressed;
         req_held_ff    <= req_buttons_held;
         req_mask_ff    <= req_repeat_mask;
      end
      if (cmd.apply) begin
         rep_ff <= '0;
      end else if (cmd.rem_start) begin
         rep_ff <= rep_ff | cur_bit;
      end
      if (cmd.rsp_load) begin
         rsp_pressed_ff  <= (req_cmd_ff == bar_pkg::CMD_POLL) ? last_pressed_ff : '0;
         rsp_repeated_ff <= (req_cmd_ff == bar_pkg::CMD_QUERY) ? rep_ff : '0;
      end
   end

   assign rsp_pressed_remapped = rsp_pressed_ff;
   assign rsp_repeated         = rsp_repeated_ff;

   a_write_armed_lane: assert property (@(posedge clock) disable iff (reset)
      cmd.fire_write |-> lane_armed_ff[lane_ff])
      else $error("fire time written for a lane that is not armed");

   a_wb_past_now: assert property (@(posedge clock) disable iff (reset)
      cmd.fire_write && time_now_ff != bar_pkg::TIME_MAX |-> fire_wb > time_now_ff)
      else $error("catch-up left fire time at or before now");

   a_start_on_fire: assert property (@(posedge clock) disable iff (reset)
      cmd.rem_start |-> stat.lane_fires && !rem_busy)
      else $error("catch-up started for a lane that does not fire");

endmodule

// ===== dv/button_auto_repeat_tb.sv =====
// self-checking testbench for the button auto-repeat block: drives request words and
// register writes, predicts every response word and compares it with what comes out
// depends on bar_pkg, the three channel interfaces and button_auto_repeat
`timescale 1ns / 100ps

module button_auto_repeat_tb;

   localparam int LANE_CNT      = bar_pkg::LANES_DEFAULT;
   localparam int SETTLE_CYCLES = 4;    // margin after the last response before a register write
   localparam int TAIL_CYCLES   = 100;  // longer than a query with every lane catching up
   localparam int STALL_PCT     = 26;

   // bits that never touch a lane, used as filler inside well-formed sequences
   localparam logic [bar_pkg::BTN_W-1:0] SAFE_JUNK = 32'hFF00_0F3F;

   // button bit of each lane, and the stick bits that also reach the d-pad lanes
   localparam int LANE_POS [LANE_CNT] = '{bar_pkg::BTN_UP, bar_pkg::BTN_DOWN,
                                          bar_pkg::BTN_LEFT, bar_pkg::BTN_RIGHT,
                                          bar_pkg::BTN_L, bar_pkg::BTN_R};
   localparam int LS_ALIAS [4] = '{bar_pkg::LS_UP, bar_pkg::LS_DOWN,
                                   bar_pkg::LS_LEFT, bar_pkg::LS_RIGHT};
   localparam int RS_ALIAS [4] = '{bar_pkg::RS_UP, bar_pkg::RS_DOWN,
                                   bar_pkg::RS_LEFT, bar_pkg::RS_RIGHT};

   typedef struct packed {
      logic [bar_pkg::BTN_W-1:0] pressed_remapped;
      logic [bar_pkg::BTN_W-1:0] repeated;
   } report_word_type;

   logic clock;
   logic reset;

   bar_req_if req_ch ();
   bar_rsp_if rsp_ch ();
   bar_csr_if csr_ch ();

   button_auto_repeat dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // predicted typematic state, kept in step with every accepted word
   logic [bar_pkg::TIME_W-1:0] now_ms = '0;
   logic [bar_pkg::BTN_W-1:0]  seen_pressed = '0;
   logic [bar_pkg::BTN_W-1:0]  seen_held = '0;
   logic                       lane_live [LANE_CNT] = '{default: 1'b0};
   logic [bar_pkg::TIME_W-1:0] lane_due [LANE_CNT] = '{default: '0};
   logic [bar_pkg::CFG_W-1:0]  delay_ms = bar_pkg::DELAY_RESET;
   logic [bar_pkg::CFG_W-1:0]  interval_ms = bar_pkg::INTERVAL_RESET;

   // responses still owed by the block, oldest first
   report_word_type due_reports [$];

   int errors = 0;
   int words_sent = 0;
   int reports_checked = 0;
   int repeats_fired = 0;
   int timing_settings = 1;

   // traffic shaping shared by the sender and the receiver
   bit steady = 1'b0;       // no idling on either side while set
   int hold_request = 0;    // asks the receiver for a long hold-off of this many cycles
   int stall_left = 0;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // time arithmetic that stops at the top of the 40-bit counter
   function automatic logic [bar_pkg::TIME_W-1:0] sat_time(input logic [63:0] a,
                                                          input logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      if (s > {24'd0, bar_pkg::TIME_MAX})
         return bar_pkg::TIME_MAX;
      return s[bar_pkg::TIME_W-1:0];
   endfunction

   // stick directions also count as the matching d-pad button
   function automatic logic [bar_pkg::BTN_W-1:0] fold_sticks(
         input logic [bar_pkg::BTN_W-1:0] w);
      logic [bar_pkg::BTN_W-1:0] f;
      f = w;
      if (w[bar_pkg::LS_UP] || w[bar_pkg::RS_UP])       f[bar_pkg::BTN_UP] = 1'b1;
      if (w[bar_pkg::LS_DOWN] || w[bar_pkg::RS_DOWN])   f[bar_pkg::BTN_DOWN] = 1'b1;
      if (w[bar_pkg::LS_LEFT] || w[bar_pkg::RS_LEFT])   f[bar_pkg::BTN_LEFT] = 1'b1;
      if (w[bar_pkg::LS_RIGHT] || w[bar_pkg::RS_RIGHT]) f[bar_pkg::BTN_RIGHT] = 1'b1;
      return f;
   endfunction

   // one request word in, the response word it owes out; updates the predicted state
   function automatic report_word_type typematic_step(
         input bar_pkg::command_type      cmd,
         input logic [bar_pkg::BTN_W-1:0] pressed,
         input logic [bar_pkg::BTN_W-1:0] held,
         input logic [bar_pkg::BTN_W-1:0] mask);
      report_word_type r;
      logic [63:0]     step_ms;
      logic [63:0]     span;
      logic [63:0]     hops;
      r = '0;
      case (cmd)
         bar_pkg::CMD_TICK: begin
            if (now_ms != bar_pkg::TIME_MAX)
               now_ms = now_ms + bar_pkg::TIME_W'(1);
         end
         bar_pkg::CMD_POLL: begin
            seen_pressed = fold_sticks(pressed);
            seen_held    = fold_sticks(held);
            for (int i = 0; i < LANE_CNT; i++) begin
               if (seen_pressed[LANE_POS[i]]) begin
                  lane_live[i] = 1'b1;
                  lane_due[i]  = sat_time({24'd0, now_ms}, {48'd0, delay_ms});
               end else if (!seen_held[LANE_POS[i]]) begin
                  lane_live[i] = 1'b0;
                  lane_due[i]  = '0;
               end
            end
            r.pressed_remapped = seen_pressed;
         end
         bar_pkg::CMD_QUERY: begin
            // an interval of zero behaves as one millisecond
            step_ms = (interval_ms == '0) ? 64'd1 : {48'd0, interval_ms};
            for (int i = 0; i < LANE_CNT; i++) begin
               if (mask[LANE_POS[i]] && lane_live[i] && seen_held[LANE_POS[i]] &&
                   !seen_pressed[LANE_POS[i]] && now_ms >= lane_due[i]) begin
                  r.repeated[LANE_POS[i]] = 1'b1;
                  // jump straight past now by whole intervals
                  span        = {24'd0, now_ms} - {24'd0, lane_due[i]};
                  hops        = span / step_ms + 64'd1;
                  lane_due[i] = sat_time({24'd0, lane_due[i]}, hops * step_ms);
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // raw button word holding the given lanes, d-pad lanes spelled by any of their aliases
   function automatic logic [bar_pkg::BTN_W-1:0] spell_lanes(input logic [LANE_CNT-1:0] lanes);
      logic [bar_pkg::BTN_W-1:0] w;
      w = '0;
      for (int i = 0; i < LANE_CNT; i++) begin
         if (lanes[i]) begin
            if (i < 4) begin
               case ($urandom_range(0, 2))
                  0:       w[LANE_POS[i]] = 1'b1;
                  1:       w[LS_ALIAS[i]] = 1'b1;
                  default: w[RS_ALIAS[i]] = 1'b1;
               endcase
            end else begin
               w[LANE_POS[i]] = 1'b1;
            end
         end
      end
      return w;
   endfunction

   // offer one request word; valid stays high after the accept until the next falling edge
   task automatic send_word(input bar_pkg::command_type cmd,
                            input logic [bar_pkg::BTN_W-1:0] pressed,
                            input logic [bar_pkg::BTN_W-1:0] held,
                            input logic [bar_pkg::BTN_W-1:0] mask);
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < STALL_PCT) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.command         <= cmd;
      req_ch.buttons_pressed <= pressed;
      req_ch.buttons_held    <= held;
      req_ch.repeat_mask     <= mask;
      do @(posedge clock); while (!req_ch.ready);
      due_reports.push_back(typematic_step(cmd, pressed, held, mask));
      words_sent++;
   endtask

   // stop offering, then wait for every owed response plus a short margin
   task automatic drain_reports(input int margin);
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (due_reports.size() != 0)
         @(posedge clock);
      repeat (margin) @(posedge clock);
   endtask

   task automatic write_csr(input bar_pkg::csr_index_type idx,
                            input logic [bar_pkg::CFG_W-1:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         bar_pkg::CSR_INITIAL_DELAY:   delay_ms = value;
         bar_pkg::CSR_REPEAT_INTERVAL: interval_ms = value;
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // timing registers only change with the block idle
   task automatic set_timing(input logic [bar_pkg::CFG_W-1:0] delay,
                             input logic [bar_pkg::CFG_W-1:0] interval);
      drain_reports(SETTLE_CYCLES);
      write_csr(bar_pkg::CSR_INITIAL_DELAY, delay);
      write_csr(bar_pkg::CSR_REPEAT_INTERVAL, interval);
      timing_settings++;
   endtask

   // reset timing: unused command, remap of both sticks, arming, no early repeat, release
   task automatic test_reset_defaults();
      send_word(bar_pkg::CMD_NOP, '1, '1, '1);
      send_word(bar_pkg::CMD_TICK, '1, '1, '1);
      send_word(bar_pkg::CMD_QUERY, '0, '0, '1);        // nothing armed yet
      send_word(bar_pkg::CMD_POLL, '1, '1, '0);         // every lane pressed at once
      send_word(bar_pkg::CMD_QUERY, '0, '0, '1);        // newly pressed lanes stay quiet
      send_word(bar_pkg::CMD_POLL, '0, '1, '0);
      send_word(bar_pkg::CMD_QUERY, '0, '0, '1);        // first repeat still 350 ms away
      send_word(bar_pkg::CMD_POLL, 32'h000F_0000, 32'h00F0_0000, '0);   // left stick press
      send_word(bar_pkg::CMD_POLL, 32'h00F0_0000, 32'h000F_0000, '0);   // right stick press
      send_word(bar_pkg::CMD_POLL, '0, '0, '1);         // everything released
      send_word(bar_pkg::CMD_QUERY, '1, '1, '0);        // empty mask
      send_word(bar_pkg::CMD_POLL, SAFE_JUNK, '0, '0);  // non-lane buttons only
      send_word(bar_pkg::CMD_NOP, '0, '0, '0);
   endtask

   // zero delay fires at once, zero interval steps by one, catch-up over several ms
   task automatic test_zero_timing();
      logic [bar_pkg::BTN_W-1:0] up_and_l;
      up_and_l = (bar_pkg::BTN_W'(1) << bar_pkg::BTN_UP) |
                 (bar_pkg::BTN_W'(1) << bar_pkg::BTN_L);
      set_timing('0, '0);
      send_word(bar_pkg::CMD_POLL, up_and_l, up_and_l, '0);
      send_word(bar_pkg::CMD_POLL, '0, up_and_l, '0);
      send_word(bar_pkg::CMD_QUERY, '0, '0, '1);        // both due right away
      send_word(bar_pkg::CMD_QUERY, '0, '0, '1);        // already moved past now
      send_word(bar_pkg::CMD_TICK, '0, '0, '0);
      send_word(bar_pkg::CMD_QUERY, '0, '0, bar_pkg::BTN_W'(1) << bar_pkg::BTN_UP);
      repeat (3) send_word(bar_pkg::CMD_TICK, '0, '0, '0);
      send_word(bar_pkg::CMD_QUERY, '0, '0, '1);        // L lags several ms behind
   endtask

   // random gestures: press, hold through ticks with queries, re-press, partial release
   task automatic run_typematic_phase(input logic [bar_pkg::CFG_W-1:0] delay,
                                      input logic [bar_pkg::CFG_W-1:0] interval,
                                      input int n_words, input int max_run);
      int                        target;
      logic [LANE_CNT-1:0]       down;
      logic [LANE_CNT-1:0]       fresh;
      logic [bar_pkg::BTN_W-1:0] mask;
      set_timing(delay, interval);
      target = words_sent + n_words;
      while (words_sent < target) begin
         if ($urandom_range(0, 99) < 12) begin
            // noise: any command, any bits
            send_word(bar_pkg::command_type'($urandom_range(0, 3)), $urandom, $urandom,
                      $urandom);
         end else begin
            down = LANE_CNT'($urandom_range(1, (1 << LANE_CNT) - 1));
            send_word(bar_pkg::CMD_POLL, spell_lanes(down) | ($urandom & SAFE_JUNK),
                      spell_lanes(down) | ($urandom & SAFE_JUNK), $urandom);
            repeat ($urandom_range(0, max_run))
               send_word(bar_pkg::CMD_TICK, $urandom, $urandom, $urandom);
            // the press only counts as held from the next poll on
            send_word(bar_pkg::CMD_POLL, $urandom & SAFE_JUNK, spell_lanes(down), $urandom);
            repeat ($urandom_range(1, 8)) begin
               repeat ($urandom_range(0, max_run))
                  send_word(bar_pkg::CMD_TICK, $urandom, $urandom, $urandom);
               case ($urandom_range(0, 9))
                  6, 7: send_word(bar_pkg::CMD_POLL, '0, spell_lanes(down), $urandom);
                  8: begin
                     fresh = LANE_CNT'($urandom);
                     down  = down | fresh;
                     send_word(bar_pkg::CMD_POLL, spell_lanes(fresh), spell_lanes(down),
                               $urandom);
                  end
                  9: begin
                     down = down & LANE_CNT'($urandom);
                     send_word(bar_pkg::CMD_POLL, '0,
                               spell_lanes(down) | ($urandom & SAFE_JUNK), '0);
                  end
                  default: begin
                     mask = ($urandom_range(0, 9) < 7) ? '1 : $urandom;
                     send_word(bar_pkg::CMD_QUERY, $urandom, $urandom, mask);
                  end
               endcase
            end
            send_word(bar_pkg::CMD_QUERY, $urandom, $urandom, '1);
            send_word(bar_pkg::CMD_POLL, $urandom & SAFE_JUNK, $urandom & SAFE_JUNK,
                      $urandom);
         end
      end
   endtask

   // receiver holds off for a long stretch while the sender keeps offering words
   task automatic test_backpressure();
      logic [LANE_CNT-1:0] down;
      down = '1;
      hold_request = 150;
      send_word(bar_pkg::CMD_POLL, spell_lanes(down), spell_lanes(down), '0);
      send_word(bar_pkg::CMD_POLL, '0, spell_lanes(down), '0);
      repeat (12) begin
         send_word(bar_pkg::CMD_TICK, $urandom, $urandom, $urandom);
         send_word(bar_pkg::CMD_QUERY, $urandom, $urandom, '1);
      end
      // sender now waits for every response before going on
      drain_reports(SETTLE_CYCLES);
      repeat (6) begin
         send_word(bar_pkg::CMD_TICK, '0, '0, '0);
         send_word(bar_pkg::CMD_QUERY, '0, '0, '1);
      end
   endtask

   // receiver: random stalls, a long hold-off on request, none while steady
   always @(negedge clock) begin
      if (hold_request > 0) begin
         stall_left   = hold_request;
         hold_request = 0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= steady || ($urandom_range(0, 99) >= STALL_PCT);
      end
   end

   // compare each response word with the oldest one owed
   always @(posedge clock) begin
      report_word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (due_reports.size() == 0) begin
            $display("%0t: response with nothing owed, got pressed_remapped %h repeated %h",
                     $time, rsp_ch.pressed_remapped, rsp_ch.repeated);
            errors++;
         end else begin
            want = due_reports.pop_front();
            reports_checked++;
            repeats_fired += $countones(want.repeated);
            if (rsp_ch.pressed_remapped !== want.pressed_remapped) begin
               $display("%0t: pressed_remapped mismatch, expected %h, got %h",
                        $time, want.pressed_remapped, rsp_ch.pressed_remapped);
               errors++;
            end
            if (rsp_ch.repeated !== want.repeated) begin
               $display("%0t: repeated mismatch, expected %h, got %h",
                        $time, want.repeated, rsp_ch.repeated);
               errors++;
            end
         end
      end
   end

   // hard stop if the block hangs
   initial begin
      #4_000_000;
      $display("%0t: timeout with %0d responses still owed", $time, due_reports.size());
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      reset                  = 1'b1;
      req_ch.valid           = 1'b0;
      req_ch.command         = bar_pkg::CMD_TICK;
      req_ch.buttons_pressed = '0;
      req_ch.buttons_held    = '0;
      req_ch.repeat_mask     = '0;
      rsp_ch.ready           = 1'b0;
      csr_ch.valid           = 1'b0;
      csr_ch.index           = bar_pkg::CSR_INITIAL_DELAY;
      csr_ch.data            = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part
      test_reset_defaults();
      test_zero_timing();

      // random gestures across timing settings, the extremes among them
      run_typematic_phase(bar_pkg::DELAY_RESET, bar_pkg::INTERVAL_RESET, 150, 100);
      run_typematic_phase(16'd3, 16'd2, 360, 8);
      run_typematic_phase(16'd1, 16'd1, 220, 5);
      steady = 1'b1;                               // a stretch with no idling at all
      run_typematic_phase(16'd5, 16'd1, 190, 6);
      steady = 1'b0;
      run_typematic_phase(16'd1, 16'hFFFF, 110, 20);
      run_typematic_phase(16'hFFFF, 16'd1, 70, 20);
      run_typematic_phase(16'hFFFF, 16'hFFFF, 40, 20);
      run_typematic_phase(16'd0, 16'd0, 130, 3);
      run_typematic_phase(16'd20, 16'd7, 120, 60);
      test_backpressure();

      drain_reports(TAIL_CYCLES);
      $display("covered %0d request words over %0d timing settings, stalls on both sides",
               words_sent, timing_settings);
      $display("checked %0d responses carrying %0d lane repeats", reports_checked,
               repeats_fired);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", errors);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
